// ===== rtl/chrt_pkg.sv =====
// ----------------------------------------------------------------------------
// chrt_pkg
// Shared types and constants of the consistent hash ring table: operation and
// status codes, and the request and response transaction layouts.
// ----------------------------------------------------------------------------
package chrt_pkg;

   localparam int ID_BITS        = 32;
   localparam int HANDLE_IO_BITS = 16;
   localparam int INDEX_IO_BITS  = 6;
   localparam int COUNT_IO_BITS  = 7;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_ADD     = 2'd1,
      OP_FIND_ID = 2'd2,
      OP_OWNER   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DUP  = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_MISS = 2'd3
   } status_type;

   typedef struct packed {
      op_type                      op;
      logic [ID_BITS-1:0]          node_id;
      logic [HANDLE_IO_BITS-1:0]   node_handle;
      logic [ID_BITS-1:0]          key_hash;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic [INDEX_IO_BITS-1:0]    found_index;
      logic [ID_BITS-1:0]          found_id;
      logic [HANDLE_IO_BITS-1:0]   found_handle;
      logic [COUNT_IO_BITS-1:0]    entry_count;
   } rsp_type;

endpackage

// ===== rtl/chrt_if.sv =====
// ----------------------------------------------------------------------------
// chrt_if
// Valid/ready channels of the hash ring table: request and response.
// ----------------------------------------------------------------------------
interface chrt_req_if;
   logic              valid;
   logic              ready;
   chrt_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface chrt_rsp_if;
   logic              valid;
   logic              ready;
   chrt_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/chrt_ram.sv =====
// ----------------------------------------------------------------------------
// chrt_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module chrt_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/chrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// chrt_ctrl
// Operation sequencer: binary search over the sorted entry RAM, insert by
// moving the upper entries one place up, and result capture.
// ----------------------------------------------------------------------------
module chrt_ctrl #(
   parameter int DEPTH       = 64,
   parameter int HANDLE_BITS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  chrt_pkg::req_type                          req_data,
   output logic                                       res_valid,
   input  logic                                       res_take,
   output chrt_pkg::rsp_type                          res_data,
   output logic                                       ram_we,
   output logic [$clog2(DEPTH)-1:0]                   ram_waddr,
   output logic [chrt_pkg::ID_BITS+HANDLE_BITS-1:0]   ram_wdata,
   output logic [$clog2(DEPTH)-1:0]                   ram_raddr,
   input  logic [chrt_pkg::ID_BITS+HANDLE_BITS-1:0]   ram_rdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int DW = chrt_pkg::ID_BITS + HANDLE_BITS;
   localparam int HIO = chrt_pkg::HANDLE_IO_BITS;
   localparam int IIO = chrt_pkg::INDEX_IO_BITS;
   localparam int CIO = chrt_pkg::COUNT_IO_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WAIT,
      ST_EVAL,
      ST_SHIFT,
      ST_INSERT,
      ST_RESULT
   } state_type;

   state_type                      state_ff;
   chrt_pkg::op_type               op_ff;
   logic [chrt_pkg::ID_BITS-1:0]   key_ff;
   logic [HANDLE_BITS-1:0]         handle_ff;
   logic [CW-1:0]                  count_ff;
   logic [CW-1:0]                  lo_ff;
   logic [CW-1:0]                  hi_ff;
   logic [CW-1:0]                  mid_ff;
   logic [CW-1:0]                  pos_ff;
   logic [CW-1:0]                  sh_ff;
   chrt_pkg::status_type           status_ff;
   logic [IIO-1:0]                 index_ff;
   logic [chrt_pkg::ID_BITS-1:0]   id_ff;
   logic [HIO-1:0]                 hout_ff;

   logic [CW:0]                    mid_sum;
   logic [CW-1:0]                  mid;
   logic                           search_done;
   logic [CW-1:0]                  pos_eff;
   logic [chrt_pkg::ID_BITS-1:0]   rd_id;
   logic [HANDLE_BITS-1:0]         rd_handle;
   logic                           hit;
   logic                           full;
   logic [CW-1:0]                  cnt_m1;
   logic [CW-1:0]                  sh_m1;
   logic [CW-1:0]                  sh_m2;
   logic [HANDLE_BITS+HIO-1:0]     nh_wide;
   logic [HANDLE_BITS-1:0]         nh_trunc;
   logic [HANDLE_BITS+HIO-1:0]     rdh_wide;
   logic [HANDLE_BITS+HIO-1:0]     kh_wide;
   logic [CW+IIO-1:0]              pos_wide;
   logic [CW+CIO-1:0]              cnt_wide;

   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid         = mid_sum[CW:1];
   assign search_done = lo_ff >= hi_ff;
   // owner lookups past the last id wrap to the first entry
   assign pos_eff     = (op_ff == chrt_pkg::OP_OWNER && lo_ff >= count_ff) ? '0 : lo_ff;
   assign rd_id       = ram_rdata[DW-1:HANDLE_BITS];
   assign rd_handle   = ram_rdata[HANDLE_BITS-1:0];
   assign hit         = (pos_ff < count_ff) && (rd_id == key_ff);
   assign full        = count_ff == CW'(DEPTH);
   assign cnt_m1      = count_ff - CW'(1);
   assign sh_m1       = sh_ff - CW'(1);
   assign sh_m2       = sh_ff - CW'(2);
   assign nh_wide     = {{HANDLE_BITS{1'b0}}, req_data.node_handle};
   assign nh_trunc    = nh_wide[HANDLE_BITS-1:0];
   assign rdh_wide    = {{HIO{1'b0}}, rd_handle};
   assign kh_wide     = {{HIO{1'b0}}, handle_ff};
   assign pos_wide    = {{IIO{1'b0}}, pos_ff};
   assign cnt_wide    = {{CIO{1'b0}}, count_ff};

   always_comb begin
      ram_raddr = '0;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = ram_rdata;
      unique case (state_ff)
         ST_SEARCH: begin
            ram_raddr = search_done ? pos_eff[AW-1:0] : mid[AW-1:0];
         end
         ST_EVAL: begin
            ram_raddr = cnt_m1[AW-1:0];
         end
         ST_SHIFT: begin
            ram_raddr = sh_m2[AW-1:0];
            ram_we    = 1'b1;
            ram_waddr = sh_ff[AW-1:0];
         end
         ST_INSERT: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
            ram_wdata = {key_ff, handle_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff     <= req_data.op;
                  key_ff    <= (req_data.op == chrt_pkg::OP_OWNER) ?
                               req_data.key_hash : req_data.node_id;
                  handle_ff <= nh_trunc;
                  lo_ff     <= '0;
                  hi_ff     <= count_ff;
                  index_ff  <= '0;
                  id_ff     <= '0;
                  hout_ff   <= '0;
                  if (req_data.op == chrt_pkg::OP_CLEAR) begin
                     count_ff  <= '0;
                     status_ff <= chrt_pkg::STATUS_OK;
                     state_ff  <= ST_RESULT;
                  end else if (req_data.op == chrt_pkg::OP_OWNER && count_ff == '0) begin
                     status_ff <= chrt_pkg::STATUS_MISS;
                     state_ff  <= ST_RESULT;
                  end else begin
                     state_ff <= ST_SEARCH;
                  end
               end
            end
            ST_SEARCH: begin
               if (search_done) begin
                  pos_ff   <= pos_eff;
                  state_ff <= ST_EVAL;
               end else begin
                  mid_ff   <= mid;
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (rd_id >= key_ff) begin
                  hi_ff <= mid_ff;
               end else begin
                  lo_ff <= mid_ff + CW'(1);
               end
               state_ff <= ST_SEARCH;
            end
            ST_EVAL: begin
               unique case (op_ff)
                  chrt_pkg::OP_ADD: begin
                     if (hit) begin
                        status_ff <= chrt_pkg::STATUS_DUP;
                        index_ff  <= pos_wide[IIO-1:0];
                        id_ff     <= rd_id;
                        hout_ff   <= rdh_wide[HIO-1:0];
                        state_ff  <= ST_RESULT;
                     end else if (full) begin
                        status_ff <= chrt_pkg::STATUS_FULL;
                        state_ff  <= ST_RESULT;
                     end else if (count_ff > pos_ff) begin
                        sh_ff    <= count_ff;
                        state_ff <= ST_SHIFT;
                     end else begin
                        state_ff <= ST_INSERT;
                     end
                  end
                  chrt_pkg::OP_FIND_ID: begin
                     if (hit) begin
                        status_ff <= chrt_pkg::STATUS_OK;
                        index_ff  <= pos_wide[IIO-1:0];
                        id_ff     <= rd_id;
                        hout_ff   <= rdh_wide[HIO-1:0];
                     end else begin
                        status_ff <= chrt_pkg::STATUS_MISS;
                     end
                     state_ff <= ST_RESULT;
                  end
                  chrt_pkg::OP_OWNER: begin
                     status_ff <= chrt_pkg::STATUS_OK;
                     index_ff  <= pos_wide[IIO-1:0];
                     id_ff     <= rd_id;
                     hout_ff   <= rdh_wide[HIO-1:0];
                     state_ff  <= ST_RESULT;
                  end
                  chrt_pkg::OP_CLEAR: begin
                     status_ff <= chrt_pkg::STATUS_OK;
                     state_ff  <= ST_RESULT;
                  end
               endcase
            end
            ST_SHIFT: begin
               // entry sh-1 arrives now and is written to sh; fetch the next one down
               if (sh_m1 > pos_ff) begin
                  sh_ff <= sh_m1;
               end else begin
                  state_ff <= ST_INSERT;
               end
            end
            ST_INSERT: begin
               count_ff  <= count_ff + CW'(1);
               status_ff <= chrt_pkg::STATUS_OK;
               index_ff  <= pos_wide[IIO-1:0];
               id_ff     <= key_ff;
               hout_ff   <= kh_wide[HIO-1:0];
               state_ff  <= ST_RESULT;
            end
            ST_RESULT: begin
               if (res_take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign res_valid = state_ff == ST_RESULT;

   always_comb begin
      res_data.status       = status_ff;
      res_data.found_index  = index_ff;
      res_data.found_id     = id_ff;
      res_data.found_handle = hout_ff;
      res_data.entry_count  = cnt_wide[CIO-1:0];
   end

endmodule

// ===== rtl/consistent_hash_ring_table_top.sv =====
// ----------------------------------------------------------------------------
// consistent_hash_ring_table_top
// Sorted table of up to DEPTH ring nodes (32-bit id, handle) held in a single
// RAM, with clear, add, find-by-id and find-owner operations; one response
// per request transaction. Lookups run a binary search over the RAM, each
// probe being one read followed by one compare. An accepted add follows the
// search by moving each entry above its slot one place up, then writes the
// new entry. One request is in progress at a time; a finished response sits
// in an output register, so the next request is taken while the previous
// response waits to be read. The RAM needs no clearing pass: only slots
// below the entry count are ever used.
// ----------------------------------------------------------------------------
module consistent_hash_ring_table_top #(
   parameter int DEPTH       = 64,
   parameter int HANDLE_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   chrt_req_if.sink      req_chan,
   chrt_rsp_if.source    rsp_chan
);

   localparam int AW = $clog2(DEPTH);
   localparam int DW = chrt_pkg::ID_BITS + HANDLE_BITS;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [DW-1:0]        ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [DW-1:0]        ram_rdata;
   logic                 res_valid;
   logic                 res_take;
   chrt_pkg::rsp_type    res_data;
   logic                 rsp_valid_ff;
   chrt_pkg::rsp_type    rsp_data_ff;

   chrt_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   chrt_ctrl #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_data  (req_chan.payload),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_data  (res_data),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // output slot is free when empty or being drained this cycle
   assign res_take = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_take && res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

// ===== rtl/chrt_checker.sv =====
// ----------------------------------------------------------------------------
// chrt_checker
// Port-level checks of the hash ring table, bound to the top level.
// ----------------------------------------------------------------------------
module chrt_checker #(
   parameter int DEPTH = 64
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input chrt_pkg::rsp_type rsp_payload
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // one request in progress at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   a_reject_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == chrt_pkg::STATUS_FULL ||
                    rsp_payload.status == chrt_pkg::STATUS_MISS)
      |-> rsp_payload.found_index == '0 && rsp_payload.found_id == '0 &&
          rsp_payload.found_handle == '0)
      else $error("rejected response carries entry data");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == chrt_pkg::STATUS_FULL
      |-> rsp_payload.entry_count == chrt_pkg::COUNT_IO_BITS'(DEPTH))
      else $error("table full reported below capacity");

endmodule

bind consistent_hash_ring_table_top chrt_checker #(
   .DEPTH (DEPTH)
) u_chrt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
